### src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned RSV_W       = 3;
    localparam int unsigned OPCODE_W    = 4;
    localparam int unsigned LEN7_W      = 7;
    localparam int unsigned EXT_CNT_W   = 4;
    localparam int unsigned KEY_IDX_W   = 2;

    // Short length codes that announce an extended length field
    localparam logic [LEN7_W-1:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [LEN7_W-1:0] LEN_CODE_EXT64 = 7'd127;

    // Byte counts of the extended length fields and of the mask key
    localparam logic [EXT_CNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [EXT_CNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [EXT_CNT_W-1:0] KEY_BYTES   = 4'd4;

    // Result queue between parser and output stage (power of two)
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified result as it travels from parser to output stage
    typedef struct packed {
        logic                has_byte;
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   key;
        logic                fin;
        logic [RSV_W-1:0]    rsv;
        logic [OPCODE_W-1:0] opcode;
        logic                masked;
        logic [LEN_W-1:0]    length;
        logic                last;
    } t_result;

endpackage

### src/wsd_front.sv
// Header parser: takes stream bytes and classifies them into result entries.
`timescale 1ns / 1ps

module wsd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [wsd_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_push,
    output wsd_pkg::t_result            o_result
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD
    } t_phase;

    t_phase                 r_phase,      n_phase;
    logic [BYTE_W-1:0]      r_hdr_flags,  n_hdr_flags;
    logic                   r_masked,     n_masked;
    logic [EXT_CNT_W-1:0]   r_ext_left,   n_ext_left;
    logic [LEN_W-1:0]       r_length,     n_length;
    logic [KEY_W-1:0]       r_key,        n_key;
    logic [LEN_W-1:0]       r_remaining,  n_remaining;
    logic [KEY_IDX_W-1:0]   r_key_idx,    n_key_idx;

    logic                   emit;
    logic                   emit_has;
    logic [BYTE_W-1:0]      emit_data;
    logic [BYTE_W-1:0]      emit_key;
    logic                   emit_last;
    logic [LEN7_W-1:0]      len7;
    logic [EXT_CNT_W-1:0]   ext_dec;
    logic [BYTE_W-1:0]      key_sel;

    assign len7    = i_byte[LEN7_W-1:0];
    assign ext_dec = r_ext_left - 1'b1;

    always_comb begin
        case (r_key_idx)
            2'd0:    key_sel = r_key[31:24];
            2'd1:    key_sel = r_key[23:16];
            2'd2:    key_sel = r_key[15:8];
            default: key_sel = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr_flags = r_hdr_flags;
        n_masked    = r_masked;
        n_ext_left  = r_ext_left;
        n_length    = r_length;
        n_key       = r_key;
        n_remaining = r_remaining;
        n_key_idx   = r_key_idx;
        emit        = 1'b0;
        emit_has    = 1'b0;
        emit_data   = '0;
        emit_key    = '0;
        emit_last   = 1'b0;

        case (r_phase)
            PH_HDR1: begin
                n_masked = i_byte[BYTE_W-1];
                if (len7 == LEN_CODE_EXT16 || len7 == LEN_CODE_EXT64) begin
                    n_length   = '0;
                    n_ext_left = (len7 == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_length = LEN_W'(len7);
                    if (i_byte[BYTE_W-1]) begin
                        n_key      = '0;
                        n_ext_left = KEY_BYTES;
                        n_phase    = PH_MASKKEY;
                    end else if (len7 == '0) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end else begin
                        n_remaining = LEN_W'(len7);
                        n_key_idx   = '0;
                        n_phase     = PH_PAYLOAD;
                    end
                end
            end

            PH_EXTLEN: begin
                n_length   = {r_length[LEN_W-BYTE_W-1:0], i_byte};
                n_ext_left = ext_dec;
                if (ext_dec == '0) begin
                    if (r_masked) begin
                        n_key      = '0;
                        n_ext_left = KEY_BYTES;
                        n_phase    = PH_MASKKEY;
                    end else if (n_length == '0) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end else begin
                        n_remaining = n_length;
                        n_key_idx   = '0;
                        n_phase     = PH_PAYLOAD;
                    end
                end
            end

            PH_MASKKEY: begin
                n_key      = {r_key[KEY_W-BYTE_W-1:0], i_byte};
                n_ext_left = ext_dec;
                if (ext_dec == '0) begin
                    if (r_length == '0) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end else begin
                        n_remaining = r_length;
                        n_key_idx   = '0;
                        n_phase     = PH_PAYLOAD;
                    end
                end
            end

            PH_PAYLOAD: begin
                n_remaining = r_remaining - 1'b1;
                n_key_idx   = r_key_idx + 1'b1;
                emit        = 1'b1;
                emit_has    = 1'b1;
                emit_data   = i_byte;
                emit_key    = r_masked ? key_sel : '0;
                emit_last   = (r_remaining == LEN_W'(1));
                if (r_remaining == LEN_W'(1)) begin
                    n_phase = PH_HDR0;
                end
            end

            default: begin
                // first header byte, and any stray phase code
                n_hdr_flags = i_byte;
                n_masked    = 1'b0;
                n_length    = '0;
                n_ext_left  = '0;
                n_phase     = PH_HDR1;
            end
        endcase
    end

    assign o_push              = i_accept & emit;
    assign o_result.has_byte   = emit_has;
    assign o_result.data       = emit_data;
    assign o_result.key        = emit_key;
    assign o_result.fin        = n_hdr_flags[7];
    assign o_result.rsv        = n_hdr_flags[6:4];
    assign o_result.opcode     = n_hdr_flags[3:0];
    assign o_result.masked     = n_masked;
    assign o_result.length     = n_length;
    assign o_result.last       = emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_hdr_flags <= '0;
            r_masked    <= 1'b0;
            r_ext_left  <= '0;
            r_length    <= '0;
            r_key       <= '0;
            r_remaining <= '0;
            r_key_idx   <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_hdr_flags <= n_hdr_flags;
            r_masked    <= n_masked;
            r_ext_left  <= n_ext_left;
            r_length    <= n_length;
            r_key       <= n_key;
            r_remaining <= n_remaining;
            r_key_idx   <= n_key_idx;
        end
    end

endmodule

### src/wsd_queue.sv
// Short result queue between the header parser and the output stage.
`timescale 1ns / 1ps

module wsd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsd_pkg::t_result  i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output wsd_pkg::t_result  o_data
);
    import wsd_pkg::*;

    t_result             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/wsd_back.sv
// Output stage: unmasks the queued byte and holds the result beat.
`timescale 1ns / 1ps

module wsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  wsd_pkg::t_result              i_data,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_has_byte,
    output logic [wsd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                          o_fin_flag,
    output logic [wsd_pkg::RSV_W-1:0]     o_reserved_bits,
    output logic [wsd_pkg::OPCODE_W-1:0]  o_frame_opcode,
    output logic                          o_was_masked,
    output logic [wsd_pkg::LEN_W-1:0]     o_frame_length,
    output logic                          o_last
);
    import wsd_pkg::*;

    logic                r_valid;
    logic                r_has_byte;
    logic [BYTE_W-1:0]   r_payload;
    logic                r_fin;
    logic [RSV_W-1:0]    r_rsv;
    logic [OPCODE_W-1:0] r_opcode;
    logic                r_masked;
    logic [LEN_W-1:0]    r_length;
    logic                r_last;

    // advance when the held beat is gone or is being taken
    assign o_pop = ~i_empty & (~r_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_has_byte <= i_data.has_byte;
            r_payload  <= i_data.data ^ i_data.key;
            r_fin      <= i_data.fin;
            r_rsv      <= i_data.rsv;
            r_opcode   <= i_data.opcode;
            r_masked   <= i_data.masked;
            r_length   <= i_data.length;
            r_last     <= i_data.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_has_byte      = r_has_byte;
    assign o_payload_byte  = r_payload;
    assign o_fin_flag      = r_fin;
    assign o_reserved_bits = r_rsv;
    assign o_frame_opcode  = r_opcode;
    assign o_was_masked    = r_masked;
    assign o_frame_length  = r_length;
    assign o_last          = r_last;

endmodule

### src/websocket_frame_deframer.sv
// WebSocket frame deframer: RFC 6455 receive-side byte stream parser, top level.
`timescale 1ns / 1ps

// Takes the received WebSocket stream one byte per beat and gives one result
// beat per payload byte, unmasked, with the frame's fin, reserved bits,
// opcode, mask flag and 64-bit length, and last set on the frame's final
// byte. A frame of zero length gives a single marker beat with has_byte low.
// Header bytes give no beat. One input byte is taken every clock cycle
// while the result queue is not full. A result beat is registered in the
// result queue and then in the output register before it is presented.
// A four-entry result queue ahead of the output register absorbs output
// stalls; the input stalls only while that queue is full.

module websocket_frame_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wsd_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_has_byte,
    output logic [wsd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                          o_fin_flag,
    output logic [wsd_pkg::RSV_W-1:0]     o_reserved_bits,
    output logic [wsd_pkg::OPCODE_W-1:0]  o_frame_opcode,
    output logic                          o_was_masked,
    output logic [wsd_pkg::LEN_W-1:0]     o_frame_length,
    output logic                          o_last
);
    import wsd_pkg::*;

    logic    in_accept;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    t_result push_data;
    t_result head_data;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid & ~q_full;

    wsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .o_push   (push),
        .o_result (push_data)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (head_data)
    );

    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_data          (head_data),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_has_byte      (o_has_byte),
        .o_payload_byte  (o_payload_byte),
        .o_fin_flag      (o_fin_flag),
        .o_reserved_bits (o_reserved_bits),
        .o_frame_opcode  (o_frame_opcode),
        .o_was_masked    (o_was_masked),
        .o_frame_length  (o_frame_length),
        .o_last          (o_last)
    );

endmodule
